// File: rtl/deq_pkg.sv
`timescale 1ns / 1ps
// Package for the double-ended byte queue: command and status codes, sizes.
// Used by the top level; no dependencies.
package deq_pkg;

    localparam int DEQ_DEPTH = 64;
    localparam int BYTE_W    = 8;
    localparam int CMD_W     = 3;
    localparam int STATUS_W  = 2;

    localparam logic [CMD_W-1:0] CMD_NONE       = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd5;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

endpackage

// File: rtl/deq_ram.sv
`timescale 1ns / 1ps
// Generic RAM with one write port and two read ports, registered read data.
// No dependencies; contents are undefined until written.
module deq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

// File: rtl/double_ended_byte_queue_top.sv
`timescale 1ns / 1ps
// Double-ended byte queue kept as a ring in one RAM with front/back pointers.
// Depends on deq_pkg and deq_ram.
// The result beat appears in the cycle after the command is accepted.
// Throughput: one command per cycle; busy stays low, since the pointer update,
// the single RAM write and the two RAM reads all happen at the accepting edge.
// Reset is synchronous and active low; it empties the queue, RAM contents stay.
module double_ended_byte_queue_top
    import deq_pkg::*;
#(
    parameter int DEPTH = DEQ_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [CMD_W-1:0]           i_command,
    input  logic [BYTE_W-1:0]          i_data_byte,
    output logic                       o_valid,
    output logic [BYTE_W-1:0]          o_front_byte,
    output logic [BYTE_W-1:0]          o_back_byte,
    output logic [$clog2(DEPTH+1)-1:0] o_fill_count,
    output logic                       o_is_empty,
    output logic [STATUS_W-1:0]        o_status
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_POS = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [AW-1:0]       r_front, n_front;
    logic [AW-1:0]       r_back, n_back;
    logic [CW-1:0]       r_count, n_count;
    logic                r_valid;
    logic [STATUS_W-1:0] r_status, n_status;
    logic                r_fwd_front, r_fwd_back;
    logic [BYTE_W-1:0]   r_wdata;

    logic                accept;
    logic                we;
    logic [AW-1:0]       waddr;
    logic [BYTE_W-1:0]   rd_front, rd_back;

    function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
        ring_next = (p == LAST_POS) ? '0 : p + AW'(1);
    endfunction

    function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] p);
        ring_prev = (p == '0) ? LAST_POS : p - AW'(1);
    endfunction

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb begin
        n_front  = r_front;
        n_back   = r_back;
        n_count  = r_count;
        n_status = ST_DONE;
        we       = 1'b0;
        waddr    = r_front;
        case (i_command)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                if (r_count == FULL_CNT) begin
                    n_status = ST_FULL;
                end else if (r_count == '0) begin
                    n_back  = r_front;
                    n_count = CW'(1);
                    we      = 1'b1;
                    waddr   = r_front;
                end else if (i_command == CMD_PUSH_FRONT) begin
                    n_front = ring_next(r_front);
                    n_count = r_count + CW'(1);
                    we      = 1'b1;
                    waddr   = n_front;
                end else begin
                    n_back  = ring_prev(r_back);
                    n_count = r_count + CW'(1);
                    we      = 1'b1;
                    waddr   = n_back;
                end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
                if (r_count == '0) begin
                    n_status = ST_EMPTY;
                end else if (r_count == CW'(1)) begin
                    n_front = '0;
                    n_back  = '0;
                    n_count = '0;
                end else if (i_command == CMD_POP_FRONT) begin
                    n_front = ring_prev(r_front);
                    n_count = r_count - CW'(1);
                end else begin
                    n_back  = ring_next(r_back);
                    n_count = r_count - CW'(1);
                end
            end
            CMD_CLEAR: begin
                n_front = '0;
                n_back  = '0;
                n_count = '0;
            end
            default: begin
            end
        endcase
    end

    deq_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk    (i_clk),
        .i_we     (accept && we),
        .i_waddr  (waddr),
        .i_wdata  (i_data_byte),
        .i_re     (accept),
        .i_raddr_a(n_front),
        .i_raddr_b(n_back),
        .o_rdata_a(rd_front),
        .o_rdata_b(rd_back)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_back  <= '0;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= accept;
            if (accept) begin
                r_front <= n_front;
                r_back  <= n_back;
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status    <= n_status;
            r_wdata     <= i_data_byte;
            r_fwd_front <= we && (waddr == n_front);
            r_fwd_back  <= we && (waddr == n_back);
        end
    end

    assign o_valid      = r_valid;
    assign o_fill_count = r_count;
    assign o_is_empty   = (r_count == '0);
    assign o_status     = r_status;
    assign o_front_byte = o_is_empty ? '0 : (r_fwd_front ? r_wdata : rd_front);
    assign o_back_byte  = o_is_empty ? '0 : (r_fwd_back ? r_wdata : rd_back);

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("fill count exceeds depth");

    a_empty_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_front == '0 && r_back == '0))
        else $error("empty queue with pointers away from zero");

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_valid)
        else $error("accepted command gave no result beat");

    a_full_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_FULL) |-> (r_count == FULL_CNT))
        else $error("push reported full while not full");

    a_single_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == CW'(1)) |-> (r_front == r_back))
        else $error("single entry with distinct front and back");
`endif

endmodule

// File: sim/double_ended_byte_queue_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for double_ended_byte_queue_top: commands are driven through the
// start/busy handshake, and every result beat is compared with a behavioral ring-buffer deque.
// Depends on deq_pkg and the queue RTL; needs no files or arguments.
module double_ended_byte_queue_top_tb;
    import deq_pkg::*;

    localparam int DEPTH          = DEQ_DEPTH;
    localparam int CNT_W          = $clog2(DEPTH + 1);
    localparam int PTR_W          = $clog2(DEPTH);
    localparam int WATCHDOG_LIMIT = 500;
    localparam int TAIL_CYCLES    = 4;

    typedef logic [CMD_W-1:0]  t_cmd;
    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [PTR_W-1:0]  t_ptr;

    localparam t_cmd CMD_SPARE_6 = 3'd6;
    localparam t_cmd CMD_SPARE_7 = 3'd7;

    typedef struct packed {
        t_byte               front_byte;
        t_byte               back_byte;
        logic [CNT_W-1:0]    fill_count;
        logic                is_empty;
        logic [STATUS_W-1:0] status;
    } t_deque_view;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                start       = 1'b0;
    t_cmd                i_command   = CMD_NONE;
    t_byte               i_data_byte = '0;
    logic                busy;
    logic                o_valid;
    t_byte               o_front_byte;
    t_byte               o_back_byte;
    logic [CNT_W-1:0]    o_fill_count;
    logic                o_is_empty;
    logic [STATUS_W-1:0] o_status;

    t_byte            ring_bytes [DEPTH];
    t_ptr             front_ptr   = '0;
    t_ptr             back_ptr    = '0;
    logic [CNT_W-1:0] bytes_held  = '0;

    t_deque_view expected_views [$];
    int          error_count     = 0;
    int          commands_sent   = 0;
    int          views_checked   = 0;
    int          dropped_pushes  = 0;
    int          empty_pops      = 0;
    int          idle_cycles     = 0;

    double_ended_byte_queue_top #(
        .DEPTH(DEPTH)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_command    (i_command),
        .i_data_byte  (i_data_byte),
        .o_valid      (o_valid),
        .o_front_byte (o_front_byte),
        .o_back_byte  (o_back_byte),
        .o_fill_count (o_fill_count),
        .o_is_empty   (o_is_empty),
        .o_status     (o_status)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_deque_view next_deque_view(t_cmd cmd, t_byte data);
        t_deque_view v;
        v.status = ST_DONE;
        case (cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                if (bytes_held == CNT_W'(DEPTH)) begin
                    v.status = ST_FULL;
                end else if (bytes_held == '0) begin
                    back_ptr              = front_ptr;
                    ring_bytes[front_ptr] = data;
                    bytes_held            = CNT_W'(1);
                end else if (cmd == CMD_PUSH_FRONT) begin
                    front_ptr             = front_ptr + 1'b1;
                    ring_bytes[front_ptr] = data;
                    bytes_held            = bytes_held + 1'b1;
                end else begin
                    back_ptr             = back_ptr - 1'b1;
                    ring_bytes[back_ptr] = data;
                    bytes_held           = bytes_held + 1'b1;
                end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
                if (bytes_held == '0) begin
                    v.status = ST_EMPTY;
                end else if (bytes_held == CNT_W'(1)) begin
                    front_ptr  = '0;
                    back_ptr   = '0;
                    bytes_held = '0;
                end else if (cmd == CMD_POP_FRONT) begin
                    front_ptr  = front_ptr - 1'b1;
                    bytes_held = bytes_held - 1'b1;
                end else begin
                    back_ptr   = back_ptr + 1'b1;
                    bytes_held = bytes_held - 1'b1;
                end
            end
            CMD_CLEAR: begin
                front_ptr  = '0;
                back_ptr   = '0;
                bytes_held = '0;
            end
            default: ;
        endcase
        v.is_empty   = (bytes_held == '0);
        v.front_byte = v.is_empty ? '0 : ring_bytes[front_ptr];
        v.back_byte  = v.is_empty ? '0 : ring_bytes[back_ptr];
        v.fill_count = bytes_held;
        return v;
    endfunction

    // Input and output beats are both sampled at the rising edge, before the design updates.
    always @(posedge i_clk) begin
        t_deque_view want;
        t_deque_view seen;
        logic        moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (start && !busy) begin
                want = next_deque_view(i_command, i_data_byte);
                expected_views = {expected_views, want};
                commands_sent++;
                if (want.status == ST_FULL) dropped_pushes++;
                if (want.status == ST_EMPTY) empty_pops++;
                moved = 1'b1;
            end
            if (o_valid) begin
                moved = 1'b1;
                seen  = '{o_front_byte, o_back_byte, o_fill_count, o_is_empty, o_status};
                if (expected_views.size() == 0) begin
                    $error("Result beat arrived with no command outstanding.");
                    error_count++;
                end else begin
                    want = expected_views[0];
                    expected_views.delete(0);
                    views_checked++;
                    if (seen.front_byte !== want.front_byte) begin
                        $error("front_byte: expected %0d, got %0d", want.front_byte,
                               seen.front_byte);
                        error_count++;
                    end
                    if (seen.back_byte !== want.back_byte) begin
                        $error("back_byte: expected %0d, got %0d", want.back_byte,
                               seen.back_byte);
                        error_count++;
                    end
                    if (seen.fill_count !== want.fill_count) begin
                        $error("fill_count: expected %0d, got %0d", want.fill_count,
                               seen.fill_count);
                        error_count++;
                    end
                    if (seen.is_empty !== want.is_empty) begin
                        $error("is_empty: expected %0d, got %0d", want.is_empty,
                               seen.is_empty);
                        error_count++;
                    end
                    if (seen.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, seen.status);
                        error_count++;
                    end
                end
            end
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired: no beat moved in %0d cycles.", WATCHDOG_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_command(t_cmd cmd, t_byte data);
        start       <= 1'b1;
        i_command   <= cmd;
        i_data_byte <= data;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic idle_gap(int idle_pct);
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic wait_for_results();
        start <= 1'b0;
        do @(negedge i_clk); while (expected_views.size() != 0);
        @(posedge i_clk);
    endtask

    // Empty pops, spare codes, pushes into an empty queue, pointer wrap and byte extremes.
    task automatic test_directed();
        t_cmd  seq_cmd [22] = '{
            CMD_POP_FRONT, CMD_POP_BACK, CMD_NONE, CMD_SPARE_6, CMD_SPARE_7, CMD_CLEAR,
            CMD_PUSH_FRONT, CMD_POP_BACK, CMD_PUSH_BACK, CMD_PUSH_FRONT, CMD_PUSH_BACK,
            CMD_PUSH_FRONT, CMD_NONE, CMD_POP_FRONT, CMD_POP_BACK, CMD_CLEAR,
            CMD_POP_FRONT, CMD_PUSH_BACK, CMD_PUSH_BACK, CMD_POP_FRONT, CMD_POP_FRONT,
            CMD_POP_BACK
        };
        t_byte seq_data [22] = '{
            8'h00, 8'hFF, 8'hFF, 8'hAA, 8'h55, 8'h00,
            8'h00, 8'h00, 8'hFF, 8'hA5, 8'h5A,
            8'hFF, 8'h00, 8'h00, 8'h00, 8'hFF,
            8'h00, 8'h00, 8'h01, 8'h00, 8'h00,
            8'h00
        };
        foreach (seq_cmd[i]) begin
            send_command(seq_cmd[i], seq_data[i]);
            idle_gap(15);
        end
        wait_for_results();
    endtask

    // Fills the ring to capacity from both ends, pushes while full, drains it past empty,
    // then fills it again from the front alone, pushes at the back while full and clears a full queue.
    task automatic test_fill_and_drain();
        for (int i = 0; i < DEPTH; i++) begin
            send_command((i % 2) ? CMD_PUSH_BACK : CMD_PUSH_FRONT, t_byte'($urandom));
            idle_gap(15);
        end
        send_command(CMD_PUSH_FRONT, t_byte'($urandom));
        send_command(CMD_PUSH_BACK, t_byte'($urandom));
        send_command(CMD_NONE, t_byte'($urandom));
        for (int i = 0; i < DEPTH + 2; i++) begin
            send_command((i % 2) ? CMD_POP_BACK : CMD_POP_FRONT, t_byte'($urandom));
            idle_gap(15);
        end
        for (int i = 0; i < DEPTH; i++) begin
            send_command(CMD_PUSH_FRONT, t_byte'($urandom));
            idle_gap(15);
        end
        send_command(CMD_PUSH_BACK, t_byte'($urandom));
        send_command(CMD_CLEAR, t_byte'($urandom));
        wait_for_results();
    endtask

    // The push/pop balance drifts from burst to burst so the fill level sweeps between
    // empty and full; clears, no-ops and spare codes are sprinkled in as noise.
    task automatic test_random(int n_items, int idle_pct);
        int   push_pct;
        int   roll;
        t_cmd cmd;
        push_pct = 50;
        for (int i = 0; i < n_items; i++) begin
            if (i % 120 == 0) push_pct = $urandom_range(10, 90);
            roll = $urandom_range(0, 99);
            if (roll < 1) begin
                cmd = CMD_CLEAR;
            end else if (roll < 5) begin
                case ($urandom_range(0, 2))
                    0: cmd = CMD_NONE;
                    1: cmd = CMD_SPARE_6;
                    default: cmd = CMD_SPARE_7;
                endcase
            end else if ($urandom_range(0, 99) < push_pct) begin
                cmd = $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
            end else begin
                cmd = $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK;
            end
            send_command(cmd, t_byte'($urandom));
            idle_gap(idle_pct);
        end
        wait_for_results();
    endtask

    initial begin
        foreach (ring_bytes[i]) ring_bytes[i] = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_fill_and_drain();
        test_random(500, 15);
        test_random(500, 67);
        test_random(550, 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Covered %0d commands and %0d result beats across three idle profiles.",
                 commands_sent, views_checked);
        $display("Pushes dropped while full: %0d; pops rejected while empty: %0d.",
                 dropped_pushes, empty_pops);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
